// ----- sv/assert_macros.svh -----
// Assertion macros used by the ringtone parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Implication checked in the same cycle.
`define RTP_ASSERT_IMPLIES(LBL, CLK, RSTN, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) else $error(MSG);
// Implication checked in the next cycle.
`define RTP_ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) else $error(MSG);
`else
`define RTP_ASSERT_IMPLIES(LBL, CLK, RSTN, ANTE, CONS, MSG)
`define RTP_ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS, MSG)
`endif

`endif

// ----- sv/rtp_pkg.sv -----
// Shared types, constants and the note letter table of the ringtone parser.
`default_nettype none

package rtp_pkg;

  // Field widths.
  localparam int CHAR_W     = 8;
  localparam int SEMI_W     = 4;
  localparam int OCT_W      = 4;
  localparam int DUR_W      = 19;
  localparam int ACC_W      = 16;
  localparam int LEN_W      = 8;
  localparam int DOCT_W     = 3;
  localparam int BPM_W      = 10;
  localparam int SHIFT_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int PH_W       = 3;
  localparam int KEY_W      = 2;

  // Divider sizing: one quotient bit per iteration.
  localparam int DIV_STEPS = DUR_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [DUR_W-1:0] DUR_ALL_ONES = '1;
  localparam logic [DUR_W-1:0] MS_PER_MIN   = 19'd60000;
  localparam logic [ACC_W-1:0] ACC_MAX      = '1;
  localparam logic [OCT_W-1:0] OCT_NONE     = 4'hF;

  // Parse phases.
  localparam logic [PH_W-1:0] PH_NAME   = 3'd0;
  localparam logic [PH_W-1:0] PH_HEADER = 3'd1;
  localparam logic [PH_W-1:0] PH_LEN    = 3'd2;
  localparam logic [PH_W-1:0] PH_LETTER = 3'd3;
  localparam logic [PH_W-1:0] PH_SHARP  = 3'd4;
  localparam logic [PH_W-1:0] PH_OCT    = 3'd5;

  // Header keys.
  localparam logic [KEY_W-1:0] KEY_NONE = 2'd0;
  localparam logic [KEY_W-1:0] KEY_D    = 2'd1;
  localparam logic [KEY_W-1:0] KEY_O    = 2'd2;
  localparam logic [KEY_W-1:0] KEY_B    = 2'd3;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_DURATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_OCTAVE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_TEMPO    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OCT_SHIFT    = 2'd3;

  localparam logic [LEN_W-1:0]   RST_DEF_DURATION = 8'd4;
  localparam logic [DOCT_W-1:0]  RST_DEF_OCTAVE   = 3'd6;
  localparam logic [BPM_W-1:0]   RST_DEF_TEMPO    = 10'd63;
  localparam logic [SHIFT_W-1:0] RST_OCT_SHIFT    = 2'd0;

  // Character codes (lower case letters are compared after folding).
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_CASE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_B  = 8'h62;
  localparam logic [CHAR_W-1:0] CH_LC_C  = 8'h63;
  localparam logic [CHAR_W-1:0] CH_LC_D  = 8'h64;
  localparam logic [CHAR_W-1:0] CH_LC_E  = 8'h65;
  localparam logic [CHAR_W-1:0] CH_LC_F  = 8'h66;
  localparam logic [CHAR_W-1:0] CH_LC_G  = 8'h67;
  localparam logic [CHAR_W-1:0] CH_LC_O  = 8'h6F;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;
    logic div_start;
    logic tempo_load;
    logic out_load;
  } rtp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic need_div;
    logic div_note;
  } rtp_status_t;

  // Semitone of a folded note letter; anything else is a rest.
  function automatic logic [SEMI_W-1:0] letter_code(input logic [CHAR_W-1:0] lc);
    logic [SEMI_W-1:0] code;
    case (lc)
      CH_LC_C: code = 4'd1;
      CH_LC_D: code = 4'd3;
      CH_LC_E: code = 4'd5;
      CH_LC_F: code = 4'd6;
      CH_LC_G: code = 4'd8;
      CH_LC_A: code = 4'd10;
      CH_LC_B: code = 4'd12;
      default: code = 4'd0;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ----- sv/ringtone_text_note_parser.sv -----
// Ringtone text note parser: takes the song text one character per word and
// gives one word per note with semitone, octave and duration in milliseconds.
// A character that neither ends a note nor sets the tempo is taken without a
// division. The ':' that ends the song name, the separator that commits a b=
// pair, and a character that ends a note each take the character, launch the
// shared divider, run the iterations of that restoring divider (one quotient
// bit per cycle) and store its result. A finished note waits in the output
// register while the next characters are taken; if a second note finishes
// before the first is taken, intake pauses until then.
// Configuration writes are always ready.
`default_nettype none

module ringtone_text_note_parser
  import rtp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [CHAR_W-1:0]     in_character,
  input  wire logic                  in_last_char,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [SEMI_W-1:0]          out_semitone,
  output logic [OCT_W-1:0]           out_octave,
  output logic [DUR_W-1:0]           out_duration_ms,
  output logic                       out_song_end,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  rtp_cmd_t         cmd;
  rtp_status_t      st;
  logic             div_done;
  logic [DUR_W-1:0] div_dividend;
  logic [ACC_W-1:0] div_divisor;
  logic [DUR_W-1:0] div_quotient;

  assign cfg_ready = 1'b1;

  // Sequencing.
  rtp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .div_done  (div_done),
    .cmd       (cmd)
  );

  // Parsing and result registers.
  rtp_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_character    (in_character),
    .in_last_char    (in_last_char),
    .cmd             (cmd),
    .st              (st),
    .div_dividend    (div_dividend),
    .div_divisor     (div_divisor),
    .div_quotient    (div_quotient),
    .out_semitone    (out_semitone),
    .out_octave      (out_octave),
    .out_duration_ms (out_duration_ms),
    .out_song_end    (out_song_end)
  );

  // Shared divider for tempo and note length.
  rtp_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

endmodule

`default_nettype wire

// ----- sv/rtp_divider.sv -----
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module rtp_divider
  import rtp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DUR_W-1:0] dividend,
  input  wire logic [ACC_W-1:0] divisor,
  output logic                  done,
  output logic [DUR_W-1:0]      quotient
);

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 done_r;
  logic [DUR_W-1:0]     quo_r;
  logic [ACC_W-1:0]     rem_r;
  logic [ACC_W-1:0]     dvs_r;

  logic [ACC_W:0]       trial;
  logic [ACC_W:0]       diff;
  logic                 fits;
  logic [ACC_W-1:0]     rem_nxt;
  logic [DUR_W-1:0]     quo_nxt;

  // Shift the next dividend bit into the remainder and try a subtract.
  always_comb begin
    trial   = {rem_r, quo_r[DUR_W-1]};
    diff    = trial - {1'b0, dvs_r};
    fits    = (trial >= {1'b0, dvs_r});
    rem_nxt = fits ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
    quo_nxt = {quo_r[DUR_W-2:0], fits};
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CNT_W'(DIV_STEPS);
      done_r <= 1'b0;
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= (cnt_r != DIV_CNT_W'(1));
      done_r <= (cnt_r == DIV_CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- sv/rtp_ctrl.sv -----
// Controller that sequences character intake, division and result handoff.
`default_nettype none
`include "assert_macros.svh"

module rtp_ctrl
  import rtp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  wire logic  out_stall,
  input  rtp_status_t st,
  input  wire logic  div_done,
  output rtp_cmd_t   cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LAUNCH = 2'd1;
  localparam logic [1:0] ST_DIV    = 2'd2;
  localparam logic [1:0] ST_HOLD   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // Next state and commands.
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    out_free  = !out_valid_r || !out_stall;
    case (state_r)
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && st.need_div) begin
          state_nxt = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          if (!st.div_note) begin
            cmd.tempo_load = 1'b1;
            state_nxt      = ST_IDLE;
          end else if (out_free) begin
            cmd.out_load = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Result word stays until the consumer takes it.
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // The divider only finishes while the controller waits for it.
  `RTP_ASSERT_IMPLIES(a_done_in_div, clk, rst_n, div_done, state_r == ST_DIV, "divider done outside DIV")
  // A new result never overwrites one that is still waiting.
  `RTP_ASSERT_IMPLIES(a_load_free, clk, rst_n, cmd.out_load, !out_valid_r || !out_stall, "result overwritten")
  // A launch is always followed by the wait for the divider.
  `RTP_ASSERT_NEXT(a_launch_div, clk, rst_n, state_r == ST_LAUNCH, state_r == ST_DIV, "launch not followed by DIV")

endmodule

`default_nettype wire

// ----- sv/rtp_datapath.sv -----
// Character decoder, parse state, configuration registers and result registers.
`default_nettype none

module rtp_datapath
  import rtp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [CHAR_W-1:0]     in_character,
  input  wire logic                  in_last_char,
  input  rtp_cmd_t                   cmd,
  output rtp_status_t                st,
  output logic [DUR_W-1:0]           div_dividend,
  output logic [ACC_W-1:0]           div_divisor,
  input  wire logic [DUR_W-1:0]      div_quotient,
  output logic [SEMI_W-1:0]          out_semitone,
  output logic [OCT_W-1:0]           out_octave,
  output logic [DUR_W-1:0]           out_duration_ms,
  output logic                       out_song_end
);

  // Configuration registers.
  logic [LEN_W-1:0]   cfg_dur_r;
  logic [DOCT_W-1:0]  cfg_oct_r;
  logic [BPM_W-1:0]   cfg_tempo_r;
  logic [SHIFT_W-1:0] cfg_shift_r;

  // Parse state.
  logic [PH_W-1:0]   phase_r, phase_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [SEMI_W-1:0] code_r, code_nxt;
  logic [OCT_W-1:0]  octd_r, octd_nxt;
  logic              dot_r, dot_nxt;
  logic [LEN_W-1:0]  sdl_r, sdl_nxt;
  logic [DOCT_W-1:0] sdo_r, sdo_nxt;
  logic [DUR_W-1:0]  whole_r;

  // Division operands and the note waiting for its duration.
  logic              div_note_r;
  logic [DUR_W-1:0]  dvd_r;
  logic [ACC_W-1:0]  dvs_r;
  logic              force_r;
  logic              pdot_r;
  logic [SEMI_W-1:0] psemi_r;
  logic [OCT_W-1:0]  poct_r;
  logic              pend_r;

  // Result registers.
  logic [SEMI_W-1:0] out_semitone_r;
  logic [OCT_W-1:0]  out_octave_r;
  logic [DUR_W-1:0]  out_duration_r;
  logic              out_song_end_r;

  // Decode helpers.
  logic [CHAR_W-1:0] lc;
  logic              is_digit;
  logic [3:0]        dval;
  logic [ACC_W+3:0]  acc_mul;
  logic [ACC_W-1:0]  acc_add;

  logic              tempo_req;
  logic [ACC_W-1:0]  tempo_bpm;
  logic              emit;
  logic              clear;
  logic [SEMI_W-1:0] emit_code;
  logic [ACC_W-1:0]  emit_acc;
  logic [OCT_W-1:0]  emit_octd;
  logic              emit_dot;
  logic [ACC_W-1:0]  emit_len;
  logic [OCT_W-1:0]  emit_oct_base;
  logic [OCT_W-1:0]  emit_oct;

  logic [DUR_W:0]    dur_sum;
  logic [DUR_W-1:0]  dur_note;

  // Saturating decimal accumulate.
  always_comb begin
    lc       = in_character | CH_CASE;
    is_digit = (in_character >= CH_ZERO) && (in_character <= CH_NINE);
    dval     = in_character[3:0];
    acc_mul  = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {16'h0000, dval};
    acc_add  = (acc_mul[ACC_W+3:ACC_W] != 4'h0) ? ACC_MAX : acc_mul[ACC_W-1:0];
  end

  // Parse step for one character.
  always_comb begin
    phase_nxt = phase_r;
    key_nxt   = key_r;
    acc_nxt   = acc_r;
    code_nxt  = code_r;
    octd_nxt  = octd_r;
    dot_nxt   = dot_r;
    sdl_nxt   = sdl_r;
    sdo_nxt   = sdo_r;
    tempo_req = 1'b0;
    tempo_bpm = acc_r;
    emit      = 1'b0;
    clear     = 1'b0;

    case (phase_r)
      PH_NAME: begin
        if (in_character == CH_COLON) begin
          sdl_nxt   = cfg_dur_r;
          sdo_nxt   = cfg_oct_r;
          tempo_req = 1'b1;
          tempo_bpm = {{(ACC_W-BPM_W){1'b0}}, cfg_tempo_r};
          key_nxt   = KEY_NONE;
          clear     = 1'b1;
          phase_nxt = PH_HEADER;
        end
      end
      PH_HEADER: begin
        if (lc == CH_LC_D) begin
          key_nxt = KEY_D;
          acc_nxt = '0;
        end else if (lc == CH_LC_O) begin
          key_nxt = KEY_O;
          acc_nxt = '0;
        end else if (lc == CH_LC_B) begin
          key_nxt = KEY_B;
          acc_nxt = '0;
        end else if (is_digit) begin
          acc_nxt = acc_add;
        end else if (in_character == CH_COMMA || in_character == CH_COLON) begin
          // Commit the pending key=value pair.
          case (key_r)
            KEY_D: begin
              if (acc_r != '0) begin
                sdl_nxt = (acc_r > ACC_W'(255)) ? '1 : acc_r[LEN_W-1:0];
              end
            end
            KEY_O: begin
              if (acc_r >= ACC_W'(3) && acc_r <= ACC_W'(7)) begin
                sdo_nxt = acc_r[DOCT_W-1:0];
              end
            end
            KEY_B: begin
              tempo_req = 1'b1;
              tempo_bpm = acc_r;
            end
            default: begin
            end
          endcase
          key_nxt = KEY_NONE;
          acc_nxt = '0;
          if (in_character == CH_COLON) begin
            clear     = 1'b1;
            phase_nxt = PH_LEN;
          end
        end
      end
      default: begin
        // Note phases.
        if (in_character == CH_COMMA) begin
          emit      = 1'b1;
          clear     = 1'b1;
          phase_nxt = PH_LEN;
        end else begin
          if (phase_r == PH_LEN) begin
            if (is_digit) begin
              acc_nxt = acc_add;
            end else if (in_character != CH_SPACE) begin
              code_nxt  = letter_code(lc);
              phase_nxt = PH_LETTER;
            end
          end else if (in_character == CH_HASH) begin
            if (phase_r == PH_LETTER) begin
              if (code_r != '0) begin
                code_nxt = code_r + 1'b1;
              end
              phase_nxt = PH_SHARP;
            end
          end else if (in_character == CH_DOT) begin
            dot_nxt = 1'b1;
            if (phase_r == PH_LETTER) begin
              phase_nxt = PH_SHARP;
            end
          end else if (is_digit) begin
            if (phase_r == PH_LETTER || phase_r == PH_SHARP) begin
              octd_nxt  = dval;
              phase_nxt = PH_OCT;
            end
          end
          if (in_last_char) begin
            emit  = 1'b1;
            clear = 1'b1;
          end
        end
      end
    endcase

    // The note as it stands before it is cleared.
    emit_code = code_nxt;
    emit_acc  = acc_nxt;
    emit_octd = octd_nxt;
    emit_dot  = dot_nxt;

    // The last character always returns to the name phase.
    if (in_last_char) begin
      key_nxt   = KEY_NONE;
      clear     = 1'b1;
      phase_nxt = PH_NAME;
    end
    if (clear) begin
      acc_nxt  = '0;
      code_nxt = '0;
      octd_nxt = OCT_NONE;
      dot_nxt  = 1'b0;
    end
  end

  // Note length divisor and octave of the finished note.
  always_comb begin
    emit_len      = (emit_acc != '0) ? emit_acc : {{(ACC_W-LEN_W){1'b0}}, sdl_r};
    emit_oct_base = (emit_octd == OCT_NONE) ? {1'b0, sdo_r} : emit_octd;
    emit_oct      = emit_oct_base + {{(OCT_W-SHIFT_W){1'b0}}, cfg_shift_r};
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_dur_r   <= RST_DEF_DURATION;
      cfg_oct_r   <= RST_DEF_OCTAVE;
      cfg_tempo_r <= RST_DEF_TEMPO;
      cfg_shift_r <= RST_OCT_SHIFT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEF_DURATION: cfg_dur_r   <= cfg_data[LEN_W-1:0];
        CFG_DEF_OCTAVE:   cfg_oct_r   <= cfg_data[DOCT_W-1:0];
        CFG_DEF_TEMPO:    cfg_tempo_r <= cfg_data[BPM_W-1:0];
        CFG_OCT_SHIFT:    cfg_shift_r <= cfg_data[SHIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Parse state update on each accepted character.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_NAME;
      key_r      <= KEY_NONE;
      acc_r      <= '0;
      code_r     <= '0;
      octd_r     <= OCT_NONE;
      dot_r      <= 1'b0;
      sdl_r      <= '0;
      sdo_r      <= '0;
      div_note_r <= 1'b0;
    end else if (cmd.accept) begin
      phase_r    <= phase_nxt;
      key_r      <= key_nxt;
      acc_r      <= acc_nxt;
      code_r     <= code_nxt;
      octd_r     <= octd_nxt;
      dot_r      <= dot_nxt;
      sdl_r      <= sdl_nxt;
      sdo_r      <= sdo_nxt;
      div_note_r <= emit;
    end
  end

  // Whole-note time is four times the quotient of 60000 by the tempo, or all ones for a zero tempo.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      whole_r <= '0;
    end else if (cmd.tempo_load) begin
      whole_r <= force_r ? DUR_ALL_ONES : {div_quotient[DUR_W-3:0], 2'b00};
    end
  end

  // Division operands and the pending note.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (emit) begin
        dvd_r   <= whole_r;
        dvs_r   <= emit_len;
        force_r <= (whole_r == DUR_ALL_ONES) || (emit_len == '0);
      end else begin
        dvd_r   <= MS_PER_MIN;
        dvs_r   <= tempo_bpm;
        force_r <= (tempo_bpm == '0);
      end
      pdot_r  <= emit_dot;
      psemi_r <= emit_code;
      poct_r  <= emit_oct;
      pend_r  <= in_last_char;
    end
  end

  // Dotted notes add half; saturate to all ones.
  always_comb begin
    dur_sum  = {1'b0, div_quotient} +
               (pdot_r ? {2'b00, div_quotient[DUR_W-1:1]} : '0);
    dur_note = (force_r || dur_sum[DUR_W]) ? DUR_ALL_ONES : dur_sum[DUR_W-1:0];
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_semitone_r <= psemi_r;
      out_octave_r   <= poct_r;
      out_duration_r <= dur_note;
      out_song_end_r <= pend_r;
    end
  end

  assign st.need_div     = emit || tempo_req;
  assign st.div_note     = div_note_r;
  assign div_dividend    = dvd_r;
  assign div_divisor     = dvs_r;
  assign out_semitone    = out_semitone_r;
  assign out_octave      = out_octave_r;
  assign out_duration_ms = out_duration_r;
  assign out_song_end    = out_song_end_r;

endmodule

`default_nettype wire
